>>> rtl/bfsa_pkg.sv
// Shared constants, descriptor type and result codes of the best-fit segment allocator.
`default_nettype none
package bfsa_pkg;
  localparam int unsigned MAX_SEGMENTS       = 8;
  localparam int unsigned BLOCKS_PER_SEGMENT = 16;
  localparam int unsigned SEG_W   = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IDX_W   = $clog2(BLOCKS_PER_SEGMENT);
  localparam int unsigned NB_W    = $clog2(BLOCKS_PER_SEGMENT + 1);
  localparam int unsigned TBL_DEPTH = MAX_SEGMENTS * BLOCKS_PER_SEGMENT;
  localparam int unsigned TBL_AW  = SEG_W + IDX_W;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned SIZE_MAX_UNITS = 4096;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_SEGMENT = 2'd2
  } status_e;

  typedef struct packed {
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] size;
    logic              used;
  } desc_t;

  localparam int unsigned DESC_W = $bits(desc_t);
endpackage
`default_nettype wire

>>> rtl/bfsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/best_fit_segment_allocator.sv
// Top level of the best-fit segment allocator: sequencer, descriptor table and result register.
//
// The heap is up to 8 segments of a configurable length in units, each tiled by at most 16
// descriptors (offset, size, used) held in one 128-entry table RAM. A request is
// worked by a small sequencer around that RAM: every descriptor visit is a read
// then a check. Allocate scans open segments newest first, opening a fresh
// segment when none fits, then shifts the tail of the chosen table up by one to
// split. Free first decodes the address by repeated subtraction, scans for the
// offset, then merges free neighbors, moving the tail down for each merge.
// in_ready_o is high only while the sequencer is idle. One result per
// request is held in an output register, so the next request may start while
// a result waits. The configuration write (segment length, clamped to 1..4096)
// is taken at any time but must only be issued while the block is idle.
`default_nettype none
module best_fit_segment_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bfsa_pkg::SIZE_W-1:0]     cfg_seg_len_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            mode_i,
  input  wire logic [bfsa_pkg::SIZE_W-1:0]     request_size_i,
  input  wire logic [bfsa_pkg::ADDR_W-1:0]     free_address_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [bfsa_pkg::ADDR_W-1:0]     address_o,
  output logic      [1:0]                      status_o
);
  import bfsa_pkg::*;

  typedef enum logic [18:0] {
    ST_IDLE      = 19'(1) << 0,
    ST_SEG       = 19'(1) << 1,
    ST_SCAN_RD   = 19'(1) << 2,
    ST_SCAN_CHK  = 19'(1) << 3,
    ST_TAKE      = 19'(1) << 4,
    ST_SHIFT_RD  = 19'(1) << 5,
    ST_SHIFT_WR  = 19'(1) << 6,
    ST_SPLIT_HI  = 19'(1) << 7,
    ST_SPLIT_LO  = 19'(1) << 8,
    ST_DIV       = 19'(1) << 9,
    ST_FSCAN_RD  = 19'(1) << 10,
    ST_FSCAN_CHK = 19'(1) << 11,
    ST_MRG_TOP   = 19'(1) << 12,
    ST_MRG_RD_B  = 19'(1) << 13,
    ST_MRG_CHK   = 19'(1) << 14,
    ST_MSH_RD    = 19'(1) << 15,
    ST_MSH_WR    = 19'(1) << 16,
    ST_FINISH    = 19'(1) << 17,
    ST_SPARE     = 19'(1) << 18
  } state_e;

  state_e state_q, state_d;

  logic [SIZE_W-1:0] segsize_q, segsize_d;
  logic [CNT_W-1:0]  seg_open_q, seg_open_d;
  logic [NB_W-1:0]   nblk_q [MAX_SEGMENTS];
  logic [NB_W-1:0]   nblk_d [MAX_SEGMENTS];

  // per-request working registers
  logic [SIZE_W-1:0] req_q, req_d;
  logic [CNT_W-1:0]  segc_q, segc_d;
  logic [SEG_W-1:0]  seg_q, seg_d;
  logic [NB_W-1:0]   i_q, i_d, j_q, j_d, bi_q, bi_d;
  logic              found_q, found_d, hit_q, hit_d, aval_q, aval_d, alloc_q, alloc_d;
  logic [SIZE_W-1:0] best_size_q, best_size_d, best_off_q, best_off_d, off_q, off_d;
  logic [ADDR_W-1:0] rem_q, rem_d;
  desc_t             a_q, a_d;
  status_e           res_stat_q, res_stat_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  status_e           out_stat_q, out_stat_d;

  // table RAM port
  logic              ram_we;
  logic [TBL_AW-1:0] ram_waddr, ram_raddr;
  desc_t             ram_wdata, ram_rdata;
  logic [DESC_W-1:0] ram_rbits;

  bfsa_ram #(.WIDTH(DESC_W), .DEPTH(TBL_DEPTH)) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rbits)
  );
  assign ram_rdata = desc_t'(ram_rbits);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign address_o   = out_addr_q;
  assign status_o    = out_stat_q;

  always_comb begin
    logic [NB_W-1:0]   n;
    logic [SIZE_W-1:0] req_eff;
    logic [SIZE_W-1:0] cfg_v;
    logic [SEG_W+SIZE_W-1:0] seg_base;

    n        = nblk_q[seg_q];
    req_eff  = (request_size_i == '0) ? SIZE_W'(1) : request_size_i;
    seg_base = (SEG_W+SIZE_W)'(seg_q) * (SEG_W+SIZE_W)'(segsize_q);

    state_d     = state_q;
    segsize_d   = segsize_q;
    seg_open_d  = seg_open_q;
    nblk_d      = nblk_q;
    req_d       = req_q;
    segc_d      = segc_q;
    seg_d       = seg_q;
    i_d         = i_q;
    j_d         = j_q;
    bi_d        = bi_q;
    found_d     = found_q;
    hit_d       = hit_q;
    aval_d      = aval_q;
    alloc_d     = alloc_q;
    best_size_d = best_size_q;
    best_off_d  = best_off_q;
    off_d       = off_q;
    rem_d       = rem_q;
    a_d         = a_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_addr_d  = out_addr_q;
    out_stat_d  = out_stat_q;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    // register write, clamped to 1..4096
    cfg_v = cfg_seg_len_i;
    if (cfg_v == '0) cfg_v = SIZE_W'(1);
    if (cfg_v > SIZE_W'(SIZE_MAX_UNITS)) cfg_v = SIZE_W'(SIZE_MAX_UNITS);
    if (cfg_valid_i) segsize_d = cfg_v;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_stat_d = STAT_OK;
          if (mode_i == MODE_FREE) begin
            alloc_d = 1'b0;
            rem_d   = free_address_i;
            segc_d  = '0;
            state_d = ST_DIV;
          end else begin
            alloc_d = 1'b1;
            req_d   = req_eff;
            if (req_eff > segsize_q) begin
              res_stat_d = STAT_TOO_LARGE;
              state_d    = ST_FINISH;
            end else begin
              segc_d  = seg_open_q;
              state_d = ST_SEG;
            end
          end
        end
      end
      ST_SEG: begin
        if (segc_q == '0) begin
          if (seg_open_q >= CNT_W'(MAX_SEGMENTS)) begin
            res_stat_d = STAT_NO_SEGMENT;
            state_d    = ST_FINISH;
          end else begin
            // open a fresh segment with one free block covering it
            seg_d       = seg_open_q[SEG_W-1:0];
            seg_open_d  = CNT_W'(seg_open_q + 1'b1);
            nblk_d[seg_open_q[SEG_W-1:0]] = NB_W'(1);
            ram_we      = 1'b1;
            ram_waddr   = {seg_open_q[SEG_W-1:0], IDX_W'(0)};
            ram_wdata   = '{offset: '0, size: segsize_q, used: 1'b0};
            bi_d        = '0;
            best_off_d  = '0;
            best_size_d = segsize_q;
            state_d     = ST_TAKE;
          end
        end else begin
          seg_d   = SEG_W'(segc_q - 1'b1);
          i_d     = '0;
          found_d = 1'b0;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (i_q < n) begin
          ram_raddr = {seg_q, i_q[IDX_W-1:0]};
          state_d   = ST_SCAN_CHK;
        end else if (found_q) begin
          state_d = ST_TAKE;
        end else begin
          segc_d  = CNT_W'(segc_q - 1'b1);
          state_d = ST_SEG;
        end
      end
      ST_SCAN_CHK: begin
        // best fit; ties keep the lower index
        if (!ram_rdata.used && ram_rdata.size >= req_q &&
            (!found_q || ram_rdata.size < best_size_q)) begin
          found_d     = 1'b1;
          best_size_d = ram_rdata.size;
          best_off_d  = ram_rdata.offset;
          bi_d        = i_q;
        end
        i_d     = NB_W'(i_q + 1'b1);
        state_d = ST_SCAN_RD;
      end
      ST_TAKE: begin
        if (best_size_q > req_q && n < NB_W'(BLOCKS_PER_SEGMENT)) begin
          j_d     = NB_W'(n - 1'b1);
          state_d = ST_SHIFT_RD;
        end else begin
          // no split: hand out the whole block
          ram_we    = 1'b1;
          ram_waddr = {seg_q, bi_q[IDX_W-1:0]};
          ram_wdata = '{offset: best_off_q, size: best_size_q, used: 1'b1};
          state_d   = ST_FINISH;
        end
      end
      ST_SHIFT_RD: begin
        if (j_q > bi_q) begin
          ram_raddr = {seg_q, j_q[IDX_W-1:0]};
          state_d   = ST_SHIFT_WR;
        end else begin
          state_d = ST_SPLIT_HI;
        end
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {seg_q, IDX_W'(j_q + 1'b1)};
        ram_wdata = ram_rdata;
        j_d       = NB_W'(j_q - 1'b1);
        state_d   = ST_SHIFT_RD;
      end
      ST_SPLIT_HI: begin
        ram_we    = 1'b1;
        ram_waddr = {seg_q, IDX_W'(bi_q + 1'b1)};
        ram_wdata = '{offset: SIZE_W'(best_off_q + req_q),
                      size:   SIZE_W'(best_size_q - req_q), used: 1'b0};
        nblk_d[seg_q] = NB_W'(n + 1'b1);
        state_d   = ST_SPLIT_LO;
      end
      ST_SPLIT_LO: begin
        ram_we    = 1'b1;
        ram_waddr = {seg_q, bi_q[IDX_W-1:0]};
        ram_wdata = '{offset: best_off_q, size: req_q, used: 1'b1};
        state_d   = ST_FINISH;
      end
      ST_DIV: begin
        // address decode by repeated subtraction, bounded by open segments
        if (segc_q >= seg_open_q) begin
          state_d = ST_FINISH;
        end else if (rem_q >= ADDR_W'(segsize_q)) begin
          rem_d  = ADDR_W'(rem_q - ADDR_W'(segsize_q));
          segc_d = CNT_W'(segc_q + 1'b1);
        end else begin
          off_d   = rem_q[SIZE_W-1:0];
          seg_d   = segc_q[SEG_W-1:0];
          i_d     = '0;
          hit_d   = 1'b0;
          state_d = ST_FSCAN_RD;
        end
      end
      ST_FSCAN_RD: begin
        if (i_q < n) begin
          ram_raddr = {seg_q, i_q[IDX_W-1:0]};
          state_d   = ST_FSCAN_CHK;
        end else if (hit_q) begin
          i_d     = '0;
          aval_d  = 1'b0;
          state_d = ST_MRG_TOP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FSCAN_CHK: begin
        if (ram_rdata.offset == off_q) begin
          ram_we    = 1'b1;
          ram_waddr = {seg_q, i_q[IDX_W-1:0]};
          ram_wdata = '{offset: ram_rdata.offset, size: ram_rdata.size, used: 1'b0};
          hit_d     = 1'b1;
        end
        i_d     = NB_W'(i_q + 1'b1);
        state_d = ST_FSCAN_RD;
      end
      ST_MRG_TOP: begin
        // a_q holds entry i when aval_q is set
        if (NB_W'(i_q + 1'b1) < n) begin
          if (aval_q) begin
            ram_raddr = {seg_q, IDX_W'(i_q + 1'b1)};
            state_d   = ST_MRG_CHK;
          end else begin
            ram_raddr = {seg_q, i_q[IDX_W-1:0]};
            state_d   = ST_MRG_RD_B;
          end
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_MRG_RD_B: begin
        a_d       = ram_rdata;
        aval_d    = 1'b1;
        ram_raddr = {seg_q, IDX_W'(i_q + 1'b1)};
        state_d   = ST_MRG_CHK;
      end
      ST_MRG_CHK: begin
        if (!a_q.used && !ram_rdata.used) begin
          a_d.size  = SIZE_W'(a_q.size + ram_rdata.size);
          ram_we    = 1'b1;
          ram_waddr = {seg_q, i_q[IDX_W-1:0]};
          ram_wdata = '{offset: a_q.offset, size: SIZE_W'(a_q.size + ram_rdata.size),
                        used: 1'b0};
          j_d       = NB_W'(i_q + 1'b1);
          state_d   = ST_MSH_RD;
        end else begin
          a_d     = ram_rdata;
          i_d     = NB_W'(i_q + 1'b1);
          state_d = ST_MRG_TOP;
        end
      end
      ST_MSH_RD: begin
        if (NB_W'(j_q + 1'b1) < n) begin
          ram_raddr = {seg_q, IDX_W'(j_q + 1'b1)};
          state_d   = ST_MSH_WR;
        end else begin
          nblk_d[seg_q] = NB_W'(n - 1'b1);
          state_d       = ST_MRG_TOP;
        end
      end
      ST_MSH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {seg_q, j_q[IDX_W-1:0]};
        ram_wdata = ram_rdata;
        j_d       = NB_W'(j_q + 1'b1);
        state_d   = ST_MSH_RD;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_addr_d  = (alloc_q && res_stat_q == STAT_OK) ?
                        ADDR_W'(seg_base + {{SEG_W{1'b0}}, best_off_q}) : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      segsize_q   <= SIZE_W'(SIZE_MAX_UNITS);
      seg_open_q  <= '0;
      nblk_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      segsize_q   <= segsize_d;
      seg_open_q  <= seg_open_d;
      nblk_q      <= nblk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    segc_q      <= segc_d;
    seg_q       <= seg_d;
    i_q         <= i_d;
    j_q         <= j_d;
    bi_q        <= bi_d;
    found_q     <= found_d;
    hit_q       <= hit_d;
    aval_q      <= aval_d;
    alloc_q     <= alloc_d;
    best_size_q <= best_size_d;
    best_off_q  <= best_off_d;
    off_q       <= off_d;
    rem_q       <= rem_d;
    a_q         <= a_d;
    res_stat_q  <= res_stat_d;
    out_addr_q  <= out_addr_d;
    out_stat_q  <= out_stat_d;
  end

  // never more segments open than exist
  a_seg_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_open_q <= CNT_W'(MAX_SEGMENTS))
    else $error("open segment count out of range");

  // a segment table never holds more descriptors than it has rows
  a_table_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_RD || state_q == ST_FSCAN_RD) |->
      (nblk_q[seg_q] <= NB_W'(BLOCKS_PER_SEGMENT) && seg_q < seg_open_q))
    else $error("descriptor count or segment index out of range");

  // a result is produced only on leaving the finish state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || out_ready_i) && state_q != ST_FINISH |=> !out_valid_q)
    else $error("result appeared without a finished request");

  // a split only happens when the table has a free row
  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SPLIT_HI |-> nblk_q[seg_q] < NB_W'(BLOCKS_PER_SEGMENT))
    else $error("split into a full table");
endmodule
`default_nettype wire

>>> tb/sv/bfsa_checker.sv
// Checker for the best-fit segment allocator: watches the channels, predicts results, compares.
module bfsa_checker
  import bfsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [SIZE_W-1:0] cfg_seg_len_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              mode_i,
  input  logic [SIZE_W-1:0] request_size_i,
  input  logic [ADDR_W-1:0] free_address_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [1:0]        status_i,
  output int                errors_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ADDR_W-1:0] address;
    status_e           status;
  } alloc_result_t;

  alloc_result_t     results_due[$];
  logic [SIZE_W-1:0] seg_units;
  logic [SIZE_W-1:0] d_offset [TBL_DEPTH];
  logic [SIZE_W-1:0] d_size   [TBL_DEPTH];
  logic              d_used   [TBL_DEPTH];
  int                seg_blocks [MAX_SEGMENTS];
  int                open_segs;

  task automatic report(input string what);
    errors_o++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Hand out block idx of seg, splitting when larger and the table has room.
  function automatic void grant(int seg, int idx, logic [SIZE_W-1:0] units);
    int base;
    int n;
    base = seg * BLOCKS_PER_SEGMENT;
    n = seg_blocks[seg];
    if (d_size[base+idx] > units && n < BLOCKS_PER_SEGMENT) begin
      for (int j = n - 1; j > idx; j--) begin
        d_offset[base+j+1] = d_offset[base+j];
        d_size[base+j+1]   = d_size[base+j];
        d_used[base+j+1]   = d_used[base+j];
      end
      d_offset[base+idx+1] = d_offset[base+idx] + units;
      d_size[base+idx+1]   = d_size[base+idx] - units;
      d_used[base+idx+1]   = 1'b0;
      d_size[base+idx]     = units;
      seg_blocks[seg]      = n + 1;
    end
    d_used[base+idx] = 1'b1;
  endfunction

  function automatic void coalesce(int seg);
    int base;
    int i;
    int n;
    base = seg * BLOCKS_PER_SEGMENT;
    i = 0;
    while (i + 1 < seg_blocks[seg]) begin
      if (!d_used[base+i] && !d_used[base+i+1]) begin
        n = seg_blocks[seg];
        d_size[base+i] += d_size[base+i+1];
        for (int j = i + 1; j + 1 < n; j++) begin
          d_offset[base+j] = d_offset[base+j+1];
          d_size[base+j]   = d_size[base+j+1];
          d_used[base+j]   = d_used[base+j+1];
        end
        d_used[base+n-1] = 1'b0;
        seg_blocks[seg] = n - 1;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic alloc_result_t serve(logic mode, logic [SIZE_W-1:0] units,
                                          logic [ADDR_W-1:0] faddr);
    alloc_result_t r;
    int base;
    int best;
    int bi;
    int seg;
    int off;
    bit hit;
    r.address = '0;
    r.status  = STAT_OK;
    if (mode == MODE_ALLOC) begin
      if (units == 0) units = 1;
      if (units > seg_units) begin
        r.status = STAT_TOO_LARGE;
        return r;
      end
      for (int s = open_segs - 1; s >= 0; s--) begin
        base = s * BLOCKS_PER_SEGMENT;
        bi = -1;
        best = 0;
        for (int i = 0; i < seg_blocks[s]; i++)
          if (!d_used[base+i] && d_size[base+i] >= units && (bi < 0 || d_size[base+i] < best)) begin
            bi = i;
            best = d_size[base+i];
          end
        if (bi >= 0) begin
          grant(s, bi, units);
          r.address = ADDR_W'(s * int'(seg_units) + int'(d_offset[base+bi]));
          return r;
        end
      end
      if (open_segs >= MAX_SEGMENTS) begin
        r.status = STAT_NO_SEGMENT;
        return r;
      end
      seg = open_segs;
      open_segs++;
      d_offset[seg*BLOCKS_PER_SEGMENT] = '0;
      d_size[seg*BLOCKS_PER_SEGMENT]   = seg_units;
      d_used[seg*BLOCKS_PER_SEGMENT]   = 1'b0;
      seg_blocks[seg] = 1;
      grant(seg, 0, units);
      r.address = ADDR_W'(seg * int'(seg_units));
    end else begin
      seg = int'(faddr) / int'(seg_units);
      off = int'(faddr) % int'(seg_units);
      if (seg < open_segs) begin
        base = seg * BLOCKS_PER_SEGMENT;
        hit = 1'b0;
        for (int i = 0; i < seg_blocks[seg]; i++)
          if (int'(d_offset[base+i]) == off) begin
            d_used[base+i] = 1'b0;
            hit = 1'b1;
          end
        if (hit) coalesce(seg);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      seg_units = SIZE_W'(SIZE_MAX_UNITS);
      open_segs = 0;
      foreach (d_used[k]) d_used[k] = 1'b0;
      foreach (seg_blocks[k]) seg_blocks[k] = 0;
      results_due.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      // results first: a request taken at this edge cannot have produced one yet
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report($sformatf("result addr=%0d status=%0d with none expected", address_i, status_i));
        end else begin
          want = results_due.pop_front();
          if (address_i !== want.address)
            report($sformatf("address %0d, expected %0d", address_i, want.address));
          if (status_i !== want.status)
            report($sformatf("status %0d, expected %0d", status_i, want.status));
        end
      end
      if (in_valid_i && in_ready_i)
        results_due.push_back(serve(mode_i, request_size_i, free_address_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_seg_len_i == 0) seg_units = 1;
        else if (cfg_seg_len_i > SIZE_MAX_UNITS) seg_units = SIZE_W'(SIZE_MAX_UNITS);
        else seg_units = cfg_seg_len_i;
      end
      pending_o = results_due.size();
    end
  end

  final if (results_due.size() != 0)
    $display("checker: %0d results never arrived", results_due.size());
endmodule

>>> tb/sv/best_fit_segment_allocator_tb.sv
// Testbench top for the best-fit segment allocator: stimulus, idling and verdict.
module best_fit_segment_allocator_tb;
  import bfsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 400;
  localparam int LONG_HOLD   = 2000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [SIZE_W-1:0] cfg_seg_len_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              mode_i;
  logic [SIZE_W-1:0] request_size_i;
  logic [ADDR_W-1:0] free_address_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ADDR_W-1:0] address_o;
  logic [1:0]        status_o;
  int                errors;
  int                pending;

  int  cycles;
  bit  quiet;          // no idling on either side
  int  holds_asked;    // long receiver hold-offs requested
  int  holds_done;
  int  sent;
  int  cur_units;      // segment size as the block sees it
  int  settings;
  logic              mode_seen[$];  // modes of accepted requests, oldest first
  logic [ADDR_W-1:0] live[$];       // addresses handed out and not yet freed

  best_fit_segment_allocator u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_seg_len_i,
    .in_valid_i, .in_ready_o, .mode_i, .request_size_i, .free_address_i,
    .out_valid_o, .out_ready_i, .address_o, .status_o
  );

  bfsa_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_seg_len_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .request_size_i, .free_address_i,
    .out_valid_i(out_valid_o), .out_ready_i, .address_i(address_o), .status_i(status_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("best_fit_segment_allocator_tb: done, errors");
      $finish;
    end
  end

  // Track granted addresses so frees mostly hit live blocks.
  always @(posedge clk_i) begin
    logic m;
    if (in_valid_i && in_ready_o) mode_seen.push_back(mode_i);
    if (out_valid_o && out_ready_i && mode_seen.size() > 0) begin
      m = mode_seen.pop_front();
      if (m == MODE_ALLOC && status_o == STAT_OK) live.push_back(address_o);
    end
  end

  // Receiver: random short stalls, plus long hold-offs on request.
  initial begin
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && holds_done < holds_asked) begin
        hold = LONG_HOLD;
        holds_done++;
      end
      if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i = 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // One request; valid stays up across back-to-back requests.
  task automatic send(input logic m, input int units, input int faddr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    mode_i         = m;
    request_size_i = SIZE_W'(units);
    free_address_i = ADDR_W'(faddr);
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic alloc(input int units);
    send(MODE_ALLOC, units, $urandom_range(0, 32767));
  endtask

  task automatic release_at(input int faddr);
    send(MODE_FREE, $urandom_range(0, 8191), faddr);
  endtask

  // Lower valid, wait out every result, then wait out the SETTLE period.
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_units(input int value);
    cfg_valid_i = 1'b1;
    cfg_seg_len_i = SIZE_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cur_units = value < 1 ? 1 : (value > SIZE_MAX_UNITS ? SIZE_MAX_UNITS : value);
    live.delete();   // old addresses decode differently now
    settings++;
  endtask

  task automatic random_request();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (live.size() > 0 && pick < 40) begin
      if ($urandom_range(0, 6) != 0) begin
        k = $urandom_range(0, live.size() - 1);
        release_at(live[k]);
        live.delete(k);
      end else begin
        release_at($urandom_range(0, 32767));
      end
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 6)       alloc($urandom_range(1, cur_units / 8 < 1 ? 1 : cur_units / 8));
      else if (pick < 8)  alloc($urandom_range(0, cur_units));
      else if (pick == 8) alloc(cur_units + $urandom_range(0, 1));
      else                alloc($urandom_range(0, 8191));
    end
  endtask

  initial begin
    int steps[6];
    steps = '{1, 100, 8191, 0, 37, 4096};
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_seg_len_i = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_ALLOC;
    request_size_i = '0;
    free_address_i = '0;
    quiet = 1'b0;
    cur_units = SIZE_MAX_UNITS;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: whole segment, too large, zero size, frees that miss or repeat.
    alloc(4096);
    alloc(4097);
    alloc(0);
    release_at(4096);
    release_at(4096);          // double free
    release_at(30000);         // segment not open
    release_at(1);             // offset matches no block
    // Fill segment 1's table; the last grant takes the whole remainder.
    for (int i = 0; i < 16; i++) alloc(1);
    drain();                   // sender pause until all results are in

    // Random phases across segment sizes; the long hold-off lands in the first.
    foreach (steps[p]) begin
      set_units(steps[p]);
      if (steps[p] == 1)
        for (int i = 0; i < 10; i++) alloc(1);   // runs out of segments
      if (p == 0) holds_asked++;
      if (p == 5) quiet = 1'b1;
      for (int i = 0; i < 130; i++) random_request();
      // Free what is live so later phases find room again.
      while (live.size() > 0 && $urandom_range(0, 3) != 0) release_at(live.pop_front());
      drain();
    end

    $display("covered %0d requests over %0d segment-size settings, with short and long",
             sent, settings + 1);
    $display("output stalls, full tables, exhausted segments and unmatched frees");
    if (errors == 0)
      $display("best_fit_segment_allocator_tb: done, clean");
    else
      $display("best_fit_segment_allocator_tb: done, errors");
    $finish;
  end
endmodule
